FILE: hw/rtl/cubic_hermite_table_interpolator_defines.svh
// Assertion helpers shared by the interpolator RTL.
`ifndef CUBIC_HERMITE_TABLE_INTERPOLATOR_DEFINES_SVH
`define CUBIC_HERMITE_TABLE_INTERPOLATOR_DEFINES_SVH

// Condition that must hold on every clock edge out of reset.
`define CHTI_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("chti: invariant violated");

// Consequence that must hold in the same cycle as the antecedent.
`define CHTI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chti: same-cycle check failed");

// Consequence that must hold in the cycle after the antecedent.
`define CHTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chti: next-cycle check failed");

`endif

FILE: hw/rtl/chti_pkg.sv
`timescale 1ns / 1ps
package chti_pkg;

    // Coefficient and result widths
    localparam int COEF_W = 40;
    localparam int VAL_W  = 32;
    // Table row: const, linear, square, cube from the lowest bit up
    localparam int DATA_W = VAL_W + 3 * COEF_W;

    localparam logic signed [63:0] COEF_MAX = 64'sd549755813887;
    localparam logic signed [63:0] COEF_MIN = -64'sd549755813888;
    localparam logic signed [63:0] VAL_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] VAL_MIN  = -64'sd2147483648;

    // Control that travels with each queued request
    typedef struct packed {
        logic is_eval;  // evaluate request, else table load
        logic wr_ok;    // load index lies inside the table
        logic oor;      // evaluate index was clamped
    } t_qctl;

    typedef struct packed {
        logic                     clip;
        logic signed [COEF_W-1:0] value;
    } t_coef_sat;

    typedef struct packed {
        logic                    clip;
        logic signed [VAL_W-1:0] value;
    } t_val_sat;

    // Clip to the 40-bit coefficient range
    function automatic t_coef_sat sat_coef(input logic signed [63:0] x);
        t_coef_sat r;
        if (x > COEF_MAX) begin
            r.clip  = 1'b1;
            r.value = COEF_MAX[COEF_W-1:0];
        end else if (x < COEF_MIN) begin
            r.clip  = 1'b1;
            r.value = COEF_MIN[COEF_W-1:0];
        end else begin
            r.clip  = 1'b0;
            r.value = x[COEF_W-1:0];
        end
        return r;
    endfunction

    // Clip to the 32-bit result range
    function automatic t_val_sat sat_val(input logic signed [63:0] x);
        t_val_sat r;
        if (x > VAL_MAX) begin
            r.clip  = 1'b1;
            r.value = VAL_MAX[VAL_W-1:0];
        end else if (x < VAL_MIN) begin
            r.clip  = 1'b1;
            r.value = VAL_MIN[VAL_W-1:0];
        end else begin
            r.clip  = 1'b0;
            r.value = x[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/cubic_hermite_table_interpolator.sv
`timescale 1ns / 1ps
// Tabulated cubic Hermite interpolator in signed fixed point (Q16.16 by
// default). A load request (tuser = 0) writes four polynomial coefficients
// of one table interval, computed from its end values and end slopes, and
// returns nothing; an evaluate request (tuser = 1) returns the interpolated
// value and slope at the query point with out-of-range and saturation flags.
// Table spacing is 2^spacing_log2 LSBs from table_start. One request is taken
// per clock unless back-pressure holds the front; the table RAM does one write
// or one read a cycle, in request order. Evaluates pass front stages, queue,
// back stages S1-S6 and result register. The table has no reset: every entry
// must be loaded before it is evaluated. Configure only while idle.
module cubic_hermite_table_interpolator #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, left_value, right_value, left_slope, right_slope,
    // query_point, zero pad
    input  logic [175:0] s_axis_tdata,
    // action
    input  logic [0:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // func_value, slope_value
    output logic [63:0]  m_axis_tdata,
    // out_of_range, saturated
    output logic [1:0]   m_axis_tuser,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    import chti_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int Q_DEPTH = 4;
    localparam int CTL_W   = $bits(t_qctl);
    localparam int Q_W     = CTL_W + IDX_W + DATA_W;
    localparam logic REG_TABLE_START = 1'b0;
    localparam logic REG_SPACING     = 1'b1;

    // Configuration registers
    logic [31:0] r_table_start;
    logic [4:0]  r_spacing_log2;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_start  <= '0;
            r_spacing_log2 <= 5'd16;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TABLE_START: r_table_start  <= pwdata;
                REG_SPACING:     r_spacing_log2 <= pwdata[4:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TABLE_START: prdata = r_table_start;
            REG_SPACING:     prdata = {27'b0, r_spacing_log2};
        endcase
    end

    // Front: accept and classify
    logic              f_push, q_full;
    t_qctl             f_ctl;
    logic [IDX_W-1:0]  f_idx;
    logic [DATA_W-1:0] f_data;

    chti_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_action       (s_axis_tuser[0]),
        .i_entry_index  (s_axis_tdata[9:0]),
        .i_left_value   (s_axis_tdata[41:10]),
        .i_right_value  (s_axis_tdata[73:42]),
        .i_left_slope   (s_axis_tdata[105:74]),
        .i_right_slope  (s_axis_tdata[137:106]),
        .i_query_point  (s_axis_tdata[169:138]),
        .i_table_start  (r_table_start),
        .i_spacing_log2 (r_spacing_log2),
        .o_push         (f_push),
        .i_q_full       (q_full),
        .o_ctl          (f_ctl),
        .o_idx          (f_idx),
        .o_data         (f_data)
    );

    // Queue between front and back
    logic [Q_W-1:0] q_head;
    logic           q_valid, q_pop;

    chti_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_idx, f_data}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    // Back: table access and evaluation
    t_qctl       b_ctl;
    logic [31:0] b_func, b_slope;
    logic        b_oor, b_sat;

    assign b_ctl = t_qctl'(q_head[Q_W-1 -: CTL_W]);

    chti_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_ctl        (b_ctl),
        .i_q_idx        (q_head[DATA_W +: IDX_W]),
        .i_q_data       (q_head[DATA_W-1:0]),
        .i_spacing_log2 (r_spacing_log2),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_func_value   (b_func),
        .o_slope_value  (b_slope),
        .o_out_of_range (b_oor),
        .o_saturated    (b_sat)
    );

    assign m_axis_tdata = {b_slope, b_func};
    assign m_axis_tuser = {b_sat, b_oor};

endmodule

FILE: hw/rtl/chti_ram.sv
`timescale 1ns / 1ps
module chti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/chti_queue.sv
`timescale 1ns / 1ps
`include "cubic_hermite_table_interpolator_defines.svh"
module chti_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;

    // Pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (do_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!do_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `CHTI_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `CHTI_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

FILE: hw/rtl/chti_front.sv
`timescale 1ns / 1ps
`include "cubic_hermite_table_interpolator_defines.svh"
module chti_front #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request side
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_action,
    input  logic [9:0]                       i_entry_index,
    input  logic [31:0]                      i_left_value,
    input  logic [31:0]                      i_right_value,
    input  logic [31:0]                      i_left_slope,
    input  logic [31:0]                      i_right_slope,
    input  logic [31:0]                      i_query_point,
    // configuration
    input  logic [31:0]                      i_table_start,
    input  logic [4:0]                       i_spacing_log2,
    // queue side
    output logic                             o_push,
    input  logic                             i_q_full,
    output chti_pkg::t_qctl                  o_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0]   o_idx,
    output logic [chti_pkg::DATA_W-1:0]      o_data
);

    import chti_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int T_W   = FRAC_BITS + 1;
    // Scaled slope width: 34-bit sum shifted left by up to 31-FRAC_BITS
    localparam int SC_W  = 34 + 31 - FRAC_BITS;
    localparam logic [4:0] F5 = 5'(FRAC_BITS);
    localparam logic ACT_EVAL = 1'b1;

    // Slope times 2^(spacing_log2 - FRAC_BITS), floor on right shifts
    function automatic logic signed [SC_W-1:0] scale_sp(input logic signed [33:0] x,
                                                        input logic [4:0] sl);
        logic signed [SC_W-1:0] xe;
        xe = {{(SC_W - 34){x[33]}}, x};
        if (sl >= F5) begin
            return xe <<< (sl - F5);
        end
        return xe >>> (F5 - sl);
    endfunction

    // Stage 1 registers
    logic                   r_f1_v;
    logic                   r_f1_eval;
    logic                   r_f1_wr_ok;
    logic [IDX_W-1:0]       r_f1_idx;
    logic [31:0]            r_f1_v0;
    logic signed [32:0]     r_f1_dv;
    logic signed [SC_W-1:0] r_f1_slin;
    logic signed [SC_W-1:0] r_f1_s2;
    logic signed [SC_W-1:0] r_f1_s1;
    logic signed [32:0]     r_f1_off;

    // Stage 2 registers
    logic                   r_f2_v;
    t_qctl                  r_f2_ctl;
    logic [IDX_W-1:0]       r_f2_idx;
    logic [DATA_W-1:0]      r_f2_data;

    logic                   f1_adv, f2_adv;
    logic signed [33:0]     sum2, sum1;
    logic signed [32:0]     dv_in, off_in;

    assign f2_adv  = !r_f2_v || !i_q_full;
    assign f1_adv  = !r_f1_v || f2_adv;
    assign o_ready = f1_adv;

    // Stage 1 arithmetic straight from the request
    assign sum2   = {{2{i_right_slope[31]}}, i_right_slope}
                  + {i_left_slope[31], i_left_slope, 1'b0};
    assign sum1   = {{2{i_right_slope[31]}}, i_right_slope}
                  + {{2{i_left_slope[31]}}, i_left_slope};
    assign dv_in  = {i_right_value[31], i_right_value} - {i_left_value[31], i_left_value};
    assign off_in = {i_query_point[31], i_query_point} - {i_table_start[31], i_table_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (f1_adv) begin
            r_f1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1_adv && i_valid) begin
            r_f1_eval  <= (i_action == ACT_EVAL);
            r_f1_wr_ok <= ({22'b0, i_entry_index} < 32'(TABLE_DEPTH));
            r_f1_idx   <= IDX_W'(i_entry_index);
            r_f1_v0    <= i_left_value;
            r_f1_dv    <= dv_in;
            r_f1_slin  <= scale_sp({{2{i_left_slope[31]}}, i_left_slope}, i_spacing_log2);
            r_f1_s2    <= scale_sp(sum2, i_spacing_log2);
            r_f1_s1    <= scale_sp(sum1, i_spacing_log2);
            r_f1_off   <= off_in;
        end
    end

    // Stage 2: coefficients for a load, interval and fraction for an evaluate
    logic signed [63:0] dv64, slin64, s2_64, s1_64;
    t_coef_sat          lin_s, sq_s, cu_s;
    logic signed [32:0] seg;
    logic [32:0]        frac, t_wide;
    t_qctl              n_ctl;
    logic [IDX_W-1:0]   n_idx;
    logic [DATA_W-1:0]  n_data;

    assign dv64   = 64'(r_f1_dv);
    assign slin64 = 64'(r_f1_slin);
    assign s2_64  = 64'(r_f1_s2);
    assign s1_64  = 64'(r_f1_s1);
    assign lin_s  = sat_coef(slin64);
    assign sq_s   = sat_coef((dv64 <<< 1) + dv64 - s2_64);
    assign cu_s   = sat_coef(s1_64 - (dv64 <<< 1));

    assign seg    = r_f1_off >>> i_spacing_log2;
    assign frac   = $unsigned(r_f1_off) & ((33'd1 << i_spacing_log2) - 33'd1);
    assign t_wide = (i_spacing_log2 >= F5) ? (frac >> (i_spacing_log2 - F5))
                                           : (frac << (F5 - i_spacing_log2));

    always_comb begin
        n_ctl.is_eval = r_f1_eval;
        n_ctl.wr_ok   = r_f1_wr_ok;
        n_ctl.oor     = 1'b0;
        n_idx         = r_f1_idx;
        n_data        = {cu_s.value, sq_s.value, lin_s.value, r_f1_v0};
        if (r_f1_eval) begin
            if (r_f1_off[32]) begin
                // below the first point
                n_ctl.oor = 1'b1;
                n_idx     = '0;
                n_data    = '0;
            end else if ($unsigned(seg) > 33'(TABLE_DEPTH - 1)) begin
                // past the last interval: end of last entry
                n_ctl.oor = 1'b1;
                n_idx     = IDX_W'(TABLE_DEPTH - 1);
                n_data    = DATA_W'({1'b1, {FRAC_BITS{1'b0}}});
            end else begin
                n_idx     = seg[IDX_W-1:0];
                n_data    = DATA_W'(t_wide[T_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (f2_adv) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f2_adv && r_f1_v) begin
            r_f2_ctl  <= n_ctl;
            r_f2_idx  <= n_idx;
            r_f2_data <= n_data;
        end
    end

    assign o_push = r_f2_v;
    assign o_ctl  = r_f2_ctl;
    assign o_idx  = r_f2_idx;
    assign o_data = r_f2_data;

    `CHTI_ASSERT_NEXT(a_f2_hold, i_clk, i_rst_n, r_f2_v && i_q_full, r_f2_v)

endmodule

FILE: hw/rtl/chti_back.sv
`timescale 1ns / 1ps
`include "cubic_hermite_table_interpolator_defines.svh"
module chti_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // queue head
    input  logic                             i_q_valid,
    output logic                             o_q_pop,
    input  chti_pkg::t_qctl                  i_q_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   i_q_idx,
    input  logic [chti_pkg::DATA_W-1:0]      i_q_data,
    // configuration
    input  logic [4:0]                       i_spacing_log2,
    // result side
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [31:0]                      o_func_value,
    output logic [31:0]                      o_slope_value,
    output logic                             o_out_of_range,
    output logic                             o_saturated
);

    import chti_pkg::*;

    localparam int T_W    = FRAC_BITS + 1;
    localparam int PROD_W = COEF_W + T_W + 1;
    localparam logic [4:0] F5 = 5'(FRAC_BITS);

    logic               stall, en;
    logic               ram_we, ram_re;
    logic [DATA_W-1:0]  ram_rdata;

    // Whole pipeline holds while the result register is not taken
    assign stall   = o_valid && !i_ready;
    assign en      = !stall;
    assign o_q_pop = i_q_valid && en;
    assign ram_we  = o_q_pop && !i_q_ctl.is_eval && i_q_ctl.wr_ok;
    assign ram_re  = o_q_pop && i_q_ctl.is_eval;

    chti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_idx),
        .i_wdata (i_q_data),
        .i_re    (ram_re),
        .i_raddr (i_q_idx),
        .o_rdata (ram_rdata)
    );

    // Table row fields
    logic signed [VAL_W-1:0]  ram_y;
    logic signed [COEF_W-1:0] ram_f, ram_g, ram_h;
    assign ram_y = ram_rdata[VAL_W-1:0];
    assign ram_f = ram_rdata[VAL_W +: COEF_W];
    assign ram_g = ram_rdata[VAL_W + COEF_W +: COEF_W];
    assign ram_h = ram_rdata[VAL_W + 2 * COEF_W +: COEF_W];

    // Valid chain
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_out_v;

    // Stage payload
    logic [T_W-1:0]           r_s1_t, r_s2_t, r_s3_t, r_s4_t, r_s5_t;
    logic                     r_s1_oor, r_s2_oor, r_s3_oor, r_s4_oor, r_s5_oor, r_s6_oor;
    logic signed [VAL_W-1:0]  r_s2_y, r_s3_y, r_s4_y, r_s5_y, r_s6_y;
    logic signed [COEF_W-1:0] r_s2_f, r_s3_f, r_s4_f;
    logic signed [COEF_W-1:0] r_s2_g;
    logic signed [PROD_W-1:0] r_s2_p1;
    logic signed [COEF_W-1:0] r_s3_acc, r_s3_dacc;
    logic signed [PROD_W-1:0] r_s4_p2, r_s4_p3;
    logic signed [COEF_W-1:0] r_s5_acc, r_s5_dacc, r_s6_dacc;
    logic signed [PROD_W-1:0] r_s6_p4;
    logic                     r_s3_clip, r_s4_clip, r_s5_clip, r_s6_clip;
    logic [31:0]              r_out_func, r_out_slope;
    logic                     r_out_oor, r_out_sat;

    // Stage 3: first Horner step for value and derivative
    logic signed [63:0] m64, g64;
    t_coef_sat          acc1_s, dacc1_s;
    assign m64     = 64'(r_s2_p1 >>> FRAC_BITS);
    assign g64     = 64'(r_s2_g);
    assign acc1_s  = sat_coef(m64 + g64);
    assign dacc1_s = sat_coef((m64 <<< 1) + m64 + (g64 <<< 1));

    // Stage 5: second Horner step
    logic signed [63:0] f64;
    t_coef_sat          acc2_s, dacc2_s;
    assign f64     = 64'(r_s4_f);
    assign acc2_s  = sat_coef(64'(r_s4_p2 >>> FRAC_BITS) + f64);
    assign dacc2_s = sat_coef(64'(r_s4_p3 >>> FRAC_BITS) + f64);

    // Stage 7: final value and derivative scaled by the spacing
    logic signed [63:0] d64, dscaled;
    t_val_sat           val_s, der_s;
    assign val_s   = sat_val(64'(r_s6_p4 >>> FRAC_BITS) + 64'(r_s6_y));
    assign d64     = 64'(r_s6_dacc);
    assign dscaled = (i_spacing_log2 >= F5) ? (d64 >>> (i_spacing_log2 - F5))
                                            : (d64 <<< (F5 - i_spacing_log2));
    assign der_s   = sat_val(dscaled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= ram_re;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_s6_v  <= r_s5_v;
            r_out_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // S1: fraction beside the table read
            r_s1_t    <= i_q_data[T_W-1:0];
            r_s1_oor  <= i_q_ctl.oor;
            // S2: H*t
            r_s2_p1   <= ram_h * $signed({1'b0, r_s1_t});
            r_s2_y    <= ram_y;
            r_s2_f    <= ram_f;
            r_s2_g    <= ram_g;
            r_s2_t    <= r_s1_t;
            r_s2_oor  <= r_s1_oor;
            // S3
            r_s3_acc  <= acc1_s.value;
            r_s3_dacc <= dacc1_s.value;
            r_s3_clip <= acc1_s.clip | dacc1_s.clip;
            r_s3_y    <= r_s2_y;
            r_s3_f    <= r_s2_f;
            r_s3_t    <= r_s2_t;
            r_s3_oor  <= r_s2_oor;
            // S4: both partial sums times t
            r_s4_p2   <= r_s3_acc * $signed({1'b0, r_s3_t});
            r_s4_p3   <= r_s3_dacc * $signed({1'b0, r_s3_t});
            r_s4_clip <= r_s3_clip;
            r_s4_y    <= r_s3_y;
            r_s4_f    <= r_s3_f;
            r_s4_t    <= r_s3_t;
            r_s4_oor  <= r_s3_oor;
            // S5
            r_s5_acc  <= acc2_s.value;
            r_s5_dacc <= dacc2_s.value;
            r_s5_clip <= r_s4_clip | acc2_s.clip | dacc2_s.clip;
            r_s5_y    <= r_s4_y;
            r_s5_t    <= r_s4_t;
            r_s5_oor  <= r_s4_oor;
            // S6: last value product
            r_s6_p4   <= r_s5_acc * $signed({1'b0, r_s5_t});
            r_s6_dacc <= r_s5_dacc;
            r_s6_clip <= r_s5_clip;
            r_s6_y    <= r_s5_y;
            r_s6_oor  <= r_s5_oor;
            // result register
            r_out_func  <= val_s.value;
            r_out_slope <= der_s.value;
            r_out_oor   <= r_s6_oor;
            r_out_sat   <= r_s6_clip | val_s.clip | der_s.clip;
        end
    end

    assign o_valid        = r_out_v;
    assign o_func_value   = r_out_func;
    assign o_slope_value  = r_out_slope;
    assign o_out_of_range = r_out_oor;
    assign o_saturated    = r_out_sat;

    `CHTI_ASSERT_ALWAYS(a_ram_port_excl, i_clk, i_rst_n, !(ram_we && ram_re))

endmodule
